### hdl/assert_macros.svh
// Assertion macros used by the checker file of this block.
// No dependencies; the using module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("checker property failed");

// Property checked on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("checker property failed during or after reset");

`endif

### hdl/iacs_pkg.sv
// Types and constants of the IRC/ANSI control stripper.
// No dependencies; imported by the top level.
package iacs_pkg;

  localparam int UNIT_W  = 16;
  localparam int QDEPTH  = 3;

  // Control code units
  localparam logic [UNIT_W-1:0] CH_BOLD    = 16'h0002;
  localparam logic [UNIT_W-1:0] CH_COLOR   = 16'h0003;
  localparam logic [UNIT_W-1:0] CH_RESET   = 16'h000F;
  localparam logic [UNIT_W-1:0] CH_REVERSE = 16'h0016;
  localparam logic [UNIT_W-1:0] CH_ESC     = 16'h001B;
  localparam logic [UNIT_W-1:0] CH_ITALIC  = 16'h001D;
  localparam logic [UNIT_W-1:0] CH_UNDERLN = 16'h001F;
  localparam logic [UNIT_W-1:0] CH_COMMA   = 16'h002C;
  localparam logic [UNIT_W-1:0] CH_DIGIT0  = 16'h0030;
  localparam logic [UNIT_W-1:0] CH_DIGIT9  = 16'h0039;
  localparam logic [UNIT_W-1:0] CH_LBRACK  = 16'h005B;
  localparam logic [UNIT_W-1:0] CSI_FINAL_LO = 16'h0040;
  localparam logic [UNIT_W-1:0] CSI_FINAL_HI = 16'h007E;

  // Scanner state, one-hot
  typedef enum logic [4:0] {
    MODE_NORMAL = 5'b00001,
    MODE_FG     = 5'b00010,
    MODE_BG     = 5'b00100,
    MODE_ESC    = 5'b01000,
    MODE_CSI    = 5'b10000
  } mode_t;

  // One result item as queued for the output
  typedef struct packed {
    logic [UNIT_W-1:0] kept_unit;
    logic              unit_present;
    logic              text_end;
    logic              run_last;
  } res_t;

endpackage

### hdl/irc_ansi_control_stripper.sv
// IRC/ANSI control stripper: removes formatting controls from a stream
// of 16-bit text code units. Depends on iacs_pkg.
//
// Usage:
//   Input channel in_*: one code unit per transfer in in_tdata, with
//   in_tlast marking the final unit of a text. Output channel out_*: the
//   kept units in out_tdata; out_tuser[0] is set when out_tdata holds a
//   unit (clear for a bare end marker), out_tuser[1] marks the last result
//   caused by one input transfer, out_tlast marks the final result of a text.
//   Each input unit is decoded in the cycle it is taken and its zero, one
//   or two results go into a three-entry output queue whose head drives
//   out_*. The input is ready while the queue holds at most one entry, so
//   one unit per cycle is sustained while the receiver takes every result;
//   a unit that yields two results (a held ESC passed on ahead of the
//   current unit) drops in_tready until the queue is back to one entry.
//   When the receiver stalls, the queue fills and in_tready drops after at
//   most two further transfers that yield results. Reset empties the queue
//   and returns the scanner to normal text mode.
module irc_ansi_control_stripper (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [iacs_pkg::UNIT_W-1:0] in_tdata,   // [15:0] code_unit
  input  logic                        in_tlast,   // text_last
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [iacs_pkg::UNIT_W-1:0] out_tdata,  // [15:0] kept_unit
  output logic [1:0]                  out_tuser,  // [0] unit_present, [1] run_last
  output logic                        out_tlast   // text_end
);
  import iacs_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  dcnt_r, dcnt_nxt;
  res_t        q_r [QDEPTH];
  res_t        q_nxt [QDEPTH];
  logic [1:0]  cnt_r, cnt_nxt;

  logic        in_acc, pop;
  logic        is_digit, is_ctl, is_color, is_esc, in_final;
  logic        plain_emit;
  mode_t       plain_mode;
  logic        emit_held, emit_unit, emit_flush;
  logic [1:0]  n_res;
  res_t        r0, r1;
  logic [1:0]  base;

  assign in_acc = in_tvalid && in_tready;
  assign pop    = out_tvalid && out_tready;

  // Classify the incoming unit.
  assign is_digit = (in_tdata >= CH_DIGIT0) && (in_tdata <= CH_DIGIT9);
  assign is_ctl   = (in_tdata == CH_BOLD) || (in_tdata == CH_RESET) ||
                    (in_tdata == CH_REVERSE) || (in_tdata == CH_ITALIC) ||
                    (in_tdata == CH_UNDERLN);
  assign is_color = (in_tdata == CH_COLOR);
  assign is_esc   = (in_tdata == CH_ESC);
  assign in_final = (in_tdata >= CSI_FINAL_LO) && (in_tdata <= CSI_FINAL_HI);

  // Handling of a unit read as ordinary text.
  assign plain_emit = !(is_ctl || is_color || is_esc);
  assign plain_mode = is_color ? MODE_FG : (is_esc ? MODE_ESC : MODE_NORMAL);

  // Scanner next state and which units are emitted.
  always_comb begin
    mode_nxt  = mode_r;
    dcnt_nxt  = dcnt_r;
    emit_held = 1'b0;
    emit_unit = 1'b0;
    unique case (mode_r)
      MODE_FG: begin
        if (is_digit && dcnt_r < 2'd2) begin
          dcnt_nxt = dcnt_r + 2'd1;
        end else if (in_tdata == CH_COMMA) begin
          mode_nxt = MODE_BG;
          dcnt_nxt = 2'd0;
        end else begin
          mode_nxt  = plain_mode;
          dcnt_nxt  = 2'd0;
          emit_unit = plain_emit;
        end
      end
      MODE_BG: begin
        if (is_digit && dcnt_r < 2'd2) begin
          if (dcnt_r == 2'd1) begin
            mode_nxt = MODE_NORMAL;
            dcnt_nxt = 2'd0;
          end else begin
            dcnt_nxt = dcnt_r + 2'd1;
          end
        end else begin
          mode_nxt  = plain_mode;
          dcnt_nxt  = 2'd0;
          emit_unit = plain_emit;
        end
      end
      MODE_ESC: begin
        dcnt_nxt = 2'd0;
        if (in_tdata == CH_LBRACK) begin
          mode_nxt = MODE_CSI;
        end else begin
          emit_held = 1'b1;
          mode_nxt  = plain_mode;
          emit_unit = plain_emit;
        end
      end
      MODE_CSI: begin
        dcnt_nxt = 2'd0;
        if (in_final) begin
          mode_nxt = MODE_NORMAL;
        end
      end
      default: begin
        mode_nxt  = plain_mode;
        dcnt_nxt  = 2'd0;
        emit_unit = plain_emit;
      end
    endcase
  end

  // A held ESC is flushed at the end of the text.
  assign emit_flush = in_tlast && (mode_nxt == MODE_ESC);

  // Assemble up to two results for this unit.
  always_comb begin
    r0 = '0;
    r1 = '0;
    n_res = 2'd0;
    if (emit_held) begin
      r0.kept_unit    = CH_ESC;
      r0.unit_present = 1'b1;
      if (emit_unit || emit_flush) begin
        r1.kept_unit    = emit_unit ? in_tdata : CH_ESC;
        r1.unit_present = 1'b1;
        r1.text_end     = in_tlast;
        r1.run_last     = 1'b1;
        n_res = 2'd2;
      end else begin
        r0.text_end = in_tlast;
        r0.run_last = 1'b1;
        n_res = 2'd1;
      end
    end else if (emit_unit || emit_flush || in_tlast) begin
      r0.kept_unit    = emit_unit ? in_tdata : (emit_flush ? CH_ESC : '0);
      r0.unit_present = emit_unit || emit_flush;
      r0.text_end     = in_tlast;
      r0.run_last     = 1'b1;
      n_res = 2'd1;
    end
  end

  // Output queue: pop from the head, append behind the remaining entries.
  assign base = cnt_r - {1'b0, pop};

  always_comb begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (pop) begin
      for (int i = 0; i < QDEPTH - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
    end
    if (in_acc && n_res != 2'd0) begin
      if (base == 2'd0) begin
        q_nxt[0] = r0;
        if (n_res == 2'd2) begin
          q_nxt[1] = r1;
        end
      end else begin
        q_nxt[1] = r0;
        if (n_res == 2'd2) begin
          q_nxt[2] = r1;
        end
      end
    end
    cnt_nxt = base + (in_acc ? n_res : 2'd0);
  end

  // State and queue registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      dcnt_r <= 2'd0;
      cnt_r  <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_acc) begin
        mode_r <= in_tlast ? MODE_NORMAL : mode_nxt;
        dcnt_r <= in_tlast ? 2'd0 : dcnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  // Ports.
  assign in_tready  = (cnt_r <= 2'd1);
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = q_r[0].kept_unit;
  assign out_tuser  = {q_r[0].run_last, q_r[0].unit_present};
  assign out_tlast  = q_r[0].text_end;

endmodule

### hdl/iacs_checker.sv
// Port-level checker for the IRC/ANSI control stripper, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module iacs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // A stalled result transfer keeps its payload.
  `ASSERT_CLK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // A bare end marker only closes a text and carries a zero unit.
  `ASSERT_CLK(a_bare_is_end, out_tvalid && !out_tuser[0] |-> out_tlast && out_tuser[1] && out_tdata == 16'h0000)

  // The end of a text is always the last result of its input unit.
  `ASSERT_CLK(a_end_run_last, out_tvalid && out_tlast |-> out_tuser[1])

  // A final input unit is never swallowed: some result closes the text.
  `ASSERT_CLK(a_last_in_ready, in_tvalid && in_tready && in_tlast |=> out_tvalid)

  // Nothing is offered right after reset.
  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid)

endmodule

bind irc_ansi_control_stripper iacs_checker u_iacs_checker (.*);

### tb/sv/irc_ansi_control_stripper_tb.sv
// Self-checking testbench for the IRC/ANSI control stripper.
// Depends on iacs_pkg and irc_ansi_control_stripper; drives texts, predicts the cleaned stream.
module irc_ansi_control_stripper_tb;
  import iacs_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_UNITS  = 480;
  localparam int NUM_PHASES   = 4;
  localparam int SEND_IDLE [NUM_PHASES] = '{0, 59, 0, 31};
  localparam int RECV_STALL[NUM_PHASES] = '{0, 0, 59, 31};
  localparam logic [UNIT_W-1:0] FORMAT_CODES[5] =
    '{CH_BOLD, CH_RESET, CH_REVERSE, CH_ITALIC, CH_UNDERLN};

  // One directed transfer; e0/e1 hold the expected results when typed is set.
  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic              last;
    logic              typed;
    logic [1:0]        n;
    res_t              e0;
    res_t              e1;
  } dir_row_t;

  localparam res_t NO_RES = '0;
  localparam int   NUM_DIR = 27;
  localparam dir_row_t DIR_ROWS[NUM_DIR] = '{
    '{16'h0000,  1'b0, 1'b1, 2'd1, '{16'h0000, 1'b1, 1'b0, 1'b1}, NO_RES},
    '{CH_BOLD,   1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
    '{CH_RESET,  1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
    '{CH_REVERSE, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
    '{CH_ITALIC, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
    '{CH_UNDERLN, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
    // Color with a third foreground digit, which is kept as text.
    '{CH_COLOR,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{16'h0031,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{16'h0032,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{16'h0033,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    // A second comma is ordinary text.
    '{CH_COLOR,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{CH_COMMA,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{CH_COMMA,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    // Two background digits close the color control.
    '{CH_COLOR,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{16'h0034,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{CH_COMMA,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{16'h0035,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{16'h0036,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    // Held ESC then ESC, then the top code unit behind a held ESC.
    '{CH_ESC,    1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{CH_ESC,    1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{16'hFFFF,  1'b0, 1'b1, 2'd2, '{CH_ESC, 1'b1, 1'b0, 1'b0},
                                   '{16'hFFFF, 1'b1, 1'b0, 1'b1}},
    // Short CSI sequence.
    '{CH_ESC,    1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{CH_LBRACK, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{16'h006D,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    // End of text: held ESC is flushed; an open color leaves a bare marker.
    '{CH_ESC,    1'b1, 1'b1, 2'd1, '{CH_ESC, 1'b1, 1'b1, 1'b1}, NO_RES},
    '{CH_COLOR,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{16'h0039,  1'b1, 1'b1, 2'd1, '{16'h0000, 1'b0, 1'b1, 1'b1}, NO_RES}
  };

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [UNIT_W-1:0] in_tdata   = '0;
  logic              in_tlast   = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [UNIT_W-1:0] out_tdata;
  logic [1:0]        out_tuser;
  logic              out_tlast;

  // Predictor state and the cleaned units still owed by the block.
  mode_t      scan_st      = MODE_NORMAL;
  logic [1:0] color_digits = '0;
  res_t       cleaned_q[$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int idle_pct       = 0;
  int stall_pct      = 0;
  res_t want_res, got_res;

  irc_ansi_control_stripper dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_color_digit(input logic [UNIT_W-1:0] u);
    return u >= CH_DIGIT0 && u <= CH_DIGIT9;
  endfunction

  // Handles a unit seen as ordinary text; returns 1 when it is kept.
  function automatic bit plain_keeps(input logic [UNIT_W-1:0] u);
    color_digits = '0;
    scan_st = MODE_NORMAL;
    if (u == CH_COLOR) begin
      scan_st = MODE_FG;
    end else if (u == CH_ESC) begin
      scan_st = MODE_ESC;
    end else if (!(u inside {FORMAT_CODES[0], FORMAT_CODES[1], FORMAT_CODES[2],
                             FORMAT_CODES[3], FORMAT_CODES[4]})) begin
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Works out the cleaned results caused by one accepted unit.
  function automatic int strip_predict(input logic [UNIT_W-1:0] u, input bit last,
                                       output res_t r0, output res_t r1);
    res_t outs[2];
    int   n;
    n = 0;
    outs[0] = '0;
    outs[1] = '0;
    case (scan_st)
      MODE_FG: begin
        if (is_color_digit(u) && color_digits < 2) begin
          color_digits++;
        end else if (u == CH_COMMA) begin
          scan_st = MODE_BG;
          color_digits = '0;
        end else if (plain_keeps(u)) begin
          outs[n].kept_unit = u;
          outs[n].unit_present = 1'b1;
          n++;
        end
      end
      MODE_BG: begin
        if (is_color_digit(u) && color_digits < 2) begin
          color_digits++;
          if (color_digits == 2) begin
            scan_st = MODE_NORMAL;
            color_digits = '0;
          end
        end else if (plain_keeps(u)) begin
          outs[n].kept_unit = u;
          outs[n].unit_present = 1'b1;
          n++;
        end
      end
      MODE_ESC: begin
        if (u == CH_LBRACK) begin
          scan_st = MODE_CSI;
          color_digits = '0;
        end else begin
          outs[n].kept_unit = CH_ESC;
          outs[n].unit_present = 1'b1;
          n++;
          if (plain_keeps(u)) begin
            outs[n].kept_unit = u;
            outs[n].unit_present = 1'b1;
            n++;
          end
        end
      end
      MODE_CSI: begin
        if (u >= CSI_FINAL_LO && u <= CSI_FINAL_HI) scan_st = MODE_NORMAL;
        color_digits = '0;
      end
      default: begin
        if (plain_keeps(u)) begin
          outs[n].kept_unit = u;
          outs[n].unit_present = 1'b1;
          n++;
        end
      end
    endcase
    // End of text: flush a held ESC, or give a bare end marker.
    if (last) begin
      if (scan_st == MODE_ESC) begin
        outs[n].kept_unit = CH_ESC;
        outs[n].unit_present = 1'b1;
        n++;
      end
      if (n == 0) n = 1;
      outs[n-1].text_end = 1'b1;
      scan_st = MODE_NORMAL;
      color_digits = '0;
    end
    if (n > 0) outs[n-1].run_last = 1'b1;
    r0 = outs[0];
    r1 = outs[1];
    return n;
  endfunction

  // Offers one unit, waits for its transfer and records what it should yield.
  task automatic push_unit(input logic [UNIT_W-1:0] u, input bit last, input bit typed,
                           input int tn, input res_t t0, input res_t t1);
    res_t p0, p1;
    int   n;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= u;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n = strip_predict(u, last, p0, p1);
    if (typed) begin
      n  = tn;
      p0 = t0;
      p1 = t1;
    end
    if (n > 0) cleaned_q.push_back(p0);
    if (n > 1) cleaned_q.push_back(p1);
  endtask

  task automatic note_mismatch(input string what, input res_t want, input res_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%s: expected unit=%h present=%b end=%b run_last=%b, got unit=%h present=%b end=%b run_last=%b",
               what, want.kept_unit, want.unit_present, want.text_end, want.run_last,
               got.kept_unit, got.unit_present, got.text_end, got.run_last);
  endtask

  // Result side: check each transfer, then pick the next ready value.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res = '{kept_unit: out_tdata, unit_present: out_tuser[0],
                  text_end: out_tlast, run_last: out_tuser[1]};
      if (cleaned_q.size() == 0) begin
        note_mismatch("unexpected result", '0, got_res);
      end else begin
        want_res = cleaned_q.pop_front();
        if (got_res !== want_res) note_mismatch("result mismatch", want_res, got_res);
      end
    end
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stimulus: reset, directed table, then random texts over the idle and stall phases.
  initial begin
    logic [UNIT_W-1:0] text_q[$];
    int ph, k, nseg, pick, keep, sent;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < NUM_DIR; k++)
      push_unit(DIR_ROWS[k].unit, DIR_ROWS[k].last, DIR_ROWS[k].typed,
                DIR_ROWS[k].n, DIR_ROWS[k].e0, DIR_ROWS[k].e1);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      idle_pct  = SEND_IDLE[ph];
      stall_pct = RECV_STALL[ph];
      sent = 0;
      while (sent < PHASE_UNITS) begin
        // Build one text from well-formed pieces with some noise mixed in.
        text_q.delete();
        nseg = $urandom_range(1, 8);
        repeat (nseg) begin
          pick = $urandom_range(99);
          if (pick < 35) begin
            repeat ($urandom_range(1, 4))
              text_q.push_back(($urandom_range(3) == 0) ? UNIT_W'($urandom)
                                                        : UNIT_W'($urandom_range(16'h20, 16'h7E)));
          end else if (pick < 45) begin
            text_q.push_back(FORMAT_CODES[$urandom_range(4)]);
          end else if (pick < 65) begin
            text_q.push_back(CH_COLOR);
            repeat ($urandom_range(0, 3))
              text_q.push_back(UNIT_W'($urandom_range(CH_DIGIT0, CH_DIGIT9)));
            if ($urandom_range(1)) begin
              text_q.push_back(CH_COMMA);
              if ($urandom_range(7) == 0) text_q.push_back(CH_COMMA);
              repeat ($urandom_range(0, 3))
                text_q.push_back(UNIT_W'($urandom_range(CH_DIGIT0, CH_DIGIT9)));
            end
          end else if (pick < 78) begin
            text_q.push_back(CH_ESC);
            text_q.push_back(CH_LBRACK);
            repeat ($urandom_range(0, 3))
              text_q.push_back(UNIT_W'($urandom_range(16'h20, 16'h3F)));
            text_q.push_back(UNIT_W'($urandom_range(CSI_FINAL_LO, CSI_FINAL_HI)));
          end else if (pick < 86) begin
            text_q.push_back(CH_ESC);
            text_q.push_back(($urandom_range(3) == 0) ? UNIT_W'($urandom)
                                                      : UNIT_W'($urandom_range(0, 16'h7F)));
          end else begin
            text_q.push_back(($urandom_range(3) == 0) ? UNIT_W'($urandom)
                                                      : UNIT_W'($urandom_range(0, 16'h7F)));
          end
        end
        // Some texts end in the middle of a sequence.
        if ($urandom_range(4) == 0) begin
          keep = $urandom_range(1, text_q.size());
          while (text_q.size() > keep) void'(text_q.pop_back());
        end
        for (k = 0; k < text_q.size(); k++)
          push_unit(text_q[k], k == text_q.size() - 1, 1'b0, 0, '0, '0);
        sent += text_q.size();
      end
    end
    in_tvalid <= 1'b0;

    // Drain, then wait for the block to show anything extra.
    while (cleaned_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && cleaned_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/iacs_pkg.sv
hdl/irc_ansi_control_stripper.sv
hdl/iacs_checker.sv
tb/sv/irc_ansi_control_stripper_tb.sv
